[sv/rssi_proximity_lock_detector_core_defines.svh]
// Assertion macros for the RSSI proximity lock detector.
// Included by the top level; depends on nothing else.
`ifndef RSSI_PROXIMITY_LOCK_DETECTOR_CORE_DEFINES_SVH
`define RSSI_PROXIMITY_LOCK_DETECTOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define RPLD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define RPLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPLD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RPLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[sv/rpld_pkg.sv]
// Shared constants for the RSSI proximity lock detector.
// No dependencies; used by the core by scoped names.
package rpld_pkg;

  // Sample and field widths
  localparam int RssiW   = 9;
  localparam int Window  = 4;
  localparam int SlotW   = $clog2(Window);
  localparam int MissW   = 4;

  // Special sample codes
  localparam logic signed [RssiW-1:0] NoSignal = -9'sd255;

  // Miss counter limits
  localparam logic [MissW-1:0] MissMax   = 4'd15;
  localparam logic [MissW-1:0] MissLimit = 4'd3;

  // Register reset values
  localparam logic signed [RssiW-1:0] UnlockThrReset = -9'sd60;
  localparam logic signed [RssiW-1:0] LockThrReset   = -9'sd80;

  // Register indexes
  typedef enum logic [1:0] {
    REG_UNLOCK_EN  = 2'd0,
    REG_LOCK_EN    = 2'd1,
    REG_UNLOCK_THR = 2'd2,
    REG_LOCK_THR   = 2'd3
  } reg_index_t;

  typedef logic signed [RssiW-1:0] rssi_t;

endpackage

[sv/rssi_proximity_lock_detector_core.sv]
// RSSI proximity lock detector: trimmed mean over a four-entry ring with
// threshold hysteresis and a missed-signal lock. Each input transaction passes
// through the input register, then the result register.
// Throughput is one transaction per cycle; stalls on the master side hold
// both registers. Reset (rst, synchronous, active high) clears the valid flags
// and detector state, not the data registers, and restores register defaults.
`include "rssi_proximity_lock_detector_core_defines.svh"

module rssi_proximity_lock_detector_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [8:0]  wr_data,
  // Sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [8:0] rssi, [15:9] zero
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] lock_pulse, [1] unlock_pulse, [2] locked,
                                 // [11:3] average, [12] average_valid, [15:13] zero
);

  localparam int W = rpld_pkg::RssiW;

  // Configuration registers
  logic          unlock_enable;
  logic          lock_enable;
  rpld_pkg::rssi_t unlock_threshold;
  rpld_pkg::rssi_t lock_threshold;

  // Detector state
  rpld_pkg::rssi_t                    sample_ring [rpld_pkg::Window];
  logic [rpld_pkg::SlotW-1:0]          write_slot;
  logic                                ring_full;
  logic                                is_locked;
  logic                                seen_signal;
  logic [rpld_pkg::MissW-1:0]          miss_count;
  rpld_pkg::rssi_t                    held_mean;

  // Pipeline registers
  logic            in_valid;
  rpld_pkg::rssi_t in_rssi;
  logic            out_valid;
  logic [15:0]     out_data;

  logic advance;

  // Next-state values
  rpld_pkg::rssi_t             ring_next [rpld_pkg::Window];
  logic [rpld_pkg::SlotW-1:0]   write_slot_next;
  logic                         ring_full_next;
  logic                         is_locked_next;
  logic                         seen_signal_next;
  logic [rpld_pkg::MissW-1:0]   miss_count_next;
  rpld_pkg::rssi_t             held_mean_next;
  logic                         lock_pulse;
  logic                         unlock_pulse;
  logic                         clear_ring;

  logic                         is_tick;
  logic                         is_sample;
  rpld_pkg::rssi_t             ring_min;
  rpld_pkg::rssi_t             ring_max;
  logic signed [W+1:0]          ring_sum;
  logic signed [W+1:0]          mid_sum;
  logic signed [W+1:0]          mid_adj;
  rpld_pkg::rssi_t             mean_use;

  // Handshake: the result register frees up when taken or empty
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_enable    <= 1'b0;
      lock_enable      <= 1'b0;
      unlock_threshold <= rpld_pkg::UnlockThrReset;
      lock_threshold   <= rpld_pkg::LockThrReset;
    end else if (wr_en) begin
      case (rpld_pkg::reg_index_t'(wr_index))
        rpld_pkg::REG_UNLOCK_EN:  unlock_enable    <= wr_data[0];
        rpld_pkg::REG_LOCK_EN:    lock_enable      <= wr_data[0];
        rpld_pkg::REG_UNLOCK_THR: unlock_threshold <= wr_data;
        rpld_pkg::REG_LOCK_THR:   lock_threshold   <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_rssi <= s_tdata[W-1:0];
    end
  end

  // Classify the sample; -256 is neither a sample nor a tick
  assign is_tick   = (in_rssi == rpld_pkg::NoSignal);
  assign is_sample = (in_rssi > rpld_pkg::NoSignal);

  // Ring write and trimmed mean over the updated ring
  always_comb begin
    for (int i = 0; i < rpld_pkg::Window; i++) begin
      ring_next[i] = sample_ring[i];
    end
    ring_next[write_slot] = in_rssi;

    ring_min = ring_next[0];
    ring_max = ring_next[0];
    ring_sum = '0;
    for (int i = 0; i < rpld_pkg::Window; i++) begin
      if (ring_next[i] < ring_min) ring_min = ring_next[i];
      if (ring_next[i] > ring_max) ring_max = ring_next[i];
      ring_sum = ring_sum + (W+2)'(ring_next[i]);
    end
    mid_sum = ring_sum - (W+2)'(ring_min) - (W+2)'(ring_max);
    // Halve, truncating toward zero
    mid_adj = mid_sum + {{(W+1){1'b0}}, mid_sum[W+1]};
  end

  // Decisions for one item
  always_comb begin
    write_slot_next  = write_slot;
    ring_full_next   = ring_full;
    is_locked_next   = is_locked;
    seen_signal_next = seen_signal;
    miss_count_next  = miss_count;
    held_mean_next   = held_mean;
    lock_pulse       = 1'b0;
    unlock_pulse     = 1'b0;
    clear_ring       = 1'b0;
    mean_use         = held_mean;

    if (is_tick && !is_locked) begin
      if (miss_count < rpld_pkg::MissMax) begin
        miss_count_next = miss_count + 1'b1;
      end
    end else if (is_sample) begin
      seen_signal_next = 1'b1;
      miss_count_next  = '0;
      write_slot_next  = write_slot + 1'b1;
      if (write_slot_next == '0) ring_full_next = 1'b1;
      if (ring_full_next) begin
        mean_use = mid_adj[W:1];
      end
      held_mean_next = mean_use;
      if (unlock_enable && (mean_use >= unlock_threshold) && is_locked) begin
        is_locked_next = 1'b0;
        unlock_pulse   = 1'b1;
      end else if (lock_enable && (mean_use <= lock_threshold) && !is_locked) begin
        is_locked_next = 1'b1;
        lock_pulse     = 1'b1;
      end
    end

    // Missed-signal lock empties the ring, keeps the mean
    if (seen_signal_next && (miss_count_next == rpld_pkg::MissLimit) && lock_enable &&
        !is_locked_next) begin
      is_locked_next  = 1'b1;
      lock_pulse      = 1'b1;
      ring_full_next  = 1'b0;
      write_slot_next = '0;
      clear_ring      = 1'b1;
    end
  end

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      ring_full   <= 1'b0;
      is_locked   <= 1'b0;
      seen_signal <= 1'b0;
      miss_count  <= '0;
      held_mean   <= '0;
    end else if (advance) begin
      write_slot  <= write_slot_next;
      ring_full   <= ring_full_next;
      is_locked   <= is_locked_next;
      seen_signal <= seen_signal_next;
      miss_count  <= miss_count_next;
      held_mean   <= held_mean_next;
    end
  end

  // Ring entries: every entry is rewritten before the ring reads as full,
  // so reset and the clear after a missed-signal lock zero them only for tidiness
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rpld_pkg::Window; i++) sample_ring[i] <= '0;
    end else if (advance) begin
      for (int i = 0; i < rpld_pkg::Window; i++) begin
        if (clear_ring) begin
          sample_ring[i] <= '0;
        end else if (is_sample) begin
          sample_ring[i] <= ring_next[i];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'b000, ring_full_next, held_mean_next, is_locked_next,
                   unlock_pulse, lock_pulse};
    end
  end

  // Checks on the detector's own logic
  `RPLD_ASSERT_IMPL(a_pulses_exclusive, clk, rst, m_tvalid, !(m_tdata[0] && m_tdata[1]), "lock and unlock pulse together")
  `RPLD_ASSERT_IMPL(a_pulse_matches_state, clk, rst, m_tvalid && (m_tdata[0] || m_tdata[1]), m_tdata[2] == m_tdata[0], "pulse disagrees with lock status")
  `RPLD_ASSERT_IMPL(a_stall_blocks_input, clk, rst, in_valid && out_valid && !m_tready, !s_tready, "input taken while result stalled")
  `RPLD_ASSERT_NEXT(a_state_holds_idle, clk, rst, !advance && !rst, $stable(miss_count) && $stable(is_locked), "state moved without an item")

endmodule
